[rtl/lane_edge_row_scan_assert.svh]
// Assertion macros shared by the lane edge row scan RTL.
`ifndef LANE_EDGE_ROW_SCAN_ASSERT_SVH
`define LANE_EDGE_ROW_SCAN_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LERS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lane edge row scan check failed");

// Check that cons holds in the cycle after ante.
`define LERS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lane edge row scan check failed");

`endif

[rtl/lers_pkg.sv]
// Types and constants shared by the lane edge row scan modules.
package lers_pkg;

    localparam int COORD_W = 10;
    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 11;
    localparam int CFG_T_W = 10;

    localparam logic [CFG_W_W-1:0] RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_H_W-1:0] RST_IMAGE_HEIGHT = 11'd1024;
    localparam logic [CFG_T_W-1:0] RST_TOLERANCE    = 10'd16;

    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TOLERANCE    = 2'd2;

    localparam logic [1:0] KIND_LEFT  = 2'd0;
    localparam logic [1:0] KIND_RIGHT = 2'd1;
    localparam logic [1:0] KIND_MID   = 2'd2;

    localparam int Q_DEPTH = 8;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    // Slots one row end may need.
    localparam int ROW_ITEMS = 3;

    typedef struct packed {
        logic pixel;
        logic frame_start;
    } t_pix_in;

    typedef struct packed {
        logic [1:0]         kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } t_res_out;

    typedef struct packed {
        logic [CFG_W_W-1:0] image_width;
        logic [CFG_H_W-1:0] image_height;
        logic [CFG_T_W-1:0] tolerance;
    } t_cfg;

    // Finished row, handed from the scanner to the result queue.
    typedef struct packed {
        logic               valid;
        logic               has_left;
        logic               has_right;
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] mid;
        logic [COORD_W-1:0] y;
    } t_row_rec;

endpackage

[rtl/lane_edge_row_scan.sv]
// Top level of the lane edge row scanner: register port, scanner and result queue.
// Throughput: one pixel transfer per cycle; a pixel that closes a row waits only while
//   the result queue cannot take three more results. Results leave one per cycle
//   while the result stream is ready. The first result of a row is offered once its
//   last pixel transfer has passed the row record register and then the result queue.
// Reset: synchronous, active low; registers return to 1024/1024/16, the scan state to
//   that of a fresh frame, and the result queue empties.
module lane_edge_row_scan #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Pixel stream.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lers_pkg::t_pix_in             i_in_data,
    // Result stream.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lers_pkg::t_res_out            o_out_data,
    // Register port.
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lers_pkg::APB_AW-1:0]   paddr,
    input  logic [lers_pkg::APB_DW-1:0]   pwdata,
    output logic [lers_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import lers_pkg::*;

    t_cfg       r_cfg;
    t_row_rec   row_rec;
    logic       room;
    logic [1:0] reg_idx;
    logic       wr_en;

    // Register index is the word address; the access phase completes at once.
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width  <= RST_IMAGE_WIDTH;
            r_cfg.image_height <= RST_IMAGE_HEIGHT;
            r_cfg.tolerance    <= RST_TOLERANCE;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  r_cfg.image_width  <= pwdata[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: r_cfg.image_height <= pwdata[CFG_H_W-1:0];
                REG_TOLERANCE:    r_cfg.tolerance    <= pwdata[CFG_T_W-1:0];
                default: begin
                    // Drop writes outside the register map.
                end
            endcase
        end
    end

    // Read back the selected register, zero outside the map.
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(r_cfg.image_width);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(r_cfg.image_height);
            REG_TOLERANCE:    prdata = APB_DW'(r_cfg.tolerance);
            default:          prdata = '0;
        endcase
    end

    // Scanner: updates edges per pixel and hands a finished row to the queue.
    lers_core #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .i_cfg   (r_cfg),
        .i_room  (room),
        .o_rec   (row_rec)
    );

    // Queue: turns each row into a transfer per found edge, plus a midpoint transfer when both are found.
    lers_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rec   (row_rec),
        .o_room  (room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

endmodule

[rtl/lers_core.sv]
// Row scanner: per-pixel edge search and row-end update of the scan state.
module lers_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lers_pkg::t_pix_in i_data,
    input  lers_pkg::t_cfg    i_cfg,
    input  logic              i_room,
    output lers_pkg::t_row_rec o_rec
);
    import lers_pkg::*;

`include "lane_edge_row_scan_assert.svh"

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int XW = (CW + 1 > CFG_W_W) ? CW + 1 : CFG_W_W;
    localparam int YW = (HW > CFG_H_W) ? HW : CFG_H_W;
    localparam int SW = ((CW > CFG_T_W) ? CW : CFG_T_W) + 1;
    localparam int RST_W = (MAX_WIDTH < int'(RST_IMAGE_WIDTH)) ? MAX_WIDTH
                                                                : int'(RST_IMAGE_WIDTH);
    localparam logic [CW-1:0] RST_RIGHT  = CW'(RST_W - 1);
    localparam logic [CW-1:0] RST_CENTRE = CW'((RST_W - 1) / 2);

    logic [CW-1:0] r_left, n_left, r_right, n_right, r_centre, n_centre;
    logic [CW-1:0] r_lc, n_lc, r_rc, n_rc, r_col, n_col;
    logic          r_fl, n_fl, r_fr, n_fr, r_halt, n_halt;
    logic [HW-1:0] r_rows, n_rows;
    t_row_rec      r_rec, n_rec;

    logic [XW-1:0] w_ext, w_eff;
    logic [YW-1:0] h_ext, h_eff;
    logic [CW-1:0] w_m1;
    logic          acc;

    // Clamp the register values to the usable range.
    always_comb begin
        w_ext = XW'(i_cfg.image_width);
        h_ext = YW'(i_cfg.image_height);
        if (w_ext == '0) begin
            w_eff = XW'(1);
        end else if (w_ext > XW'(MAX_WIDTH)) begin
            w_eff = XW'(MAX_WIDTH);
        end else begin
            w_eff = w_ext;
        end
        if (h_ext == '0) begin
            h_eff = YW'(1);
        end else if (h_ext > YW'(MAX_HEIGHT)) begin
            h_eff = YW'(MAX_HEIGHT);
        end else begin
            h_eff = h_ext;
        end
        w_m1 = CW'(w_eff - XW'(1));
    end

    // Stall only when this pixel may close a row and the queue lacks room.
    assign o_ready = (r_col < w_m1) || i_room;
    assign acc     = i_valid && o_ready;
    assign o_rec   = r_rec;

    logic [CW-1:0] c_left, c_right, c_centre, c_lc, c_rc, c_col;
    logic          c_fl, c_fr, c_halt;
    logic [HW-1:0] c_rows;
    logic [SW-1:0] left_s, right_s, tol_s, wm1_s, col_s, lb, rb, rsum;
    logic          pix, lhit, rhit;
    logic [CW-1:0] e_left, e_right;
    logic [CW:0]   esum;
    logic [HW-1:0] rows_inc;
    logic [YW-1:0] rows_s, y_full;

    always_comb begin
        // Frame start loads the fresh-frame state before the pixel is used.
        if (i_data.frame_start) begin
            c_left   = '0;
            c_right  = w_m1;
            c_centre = w_m1 >> 1;
            c_lc     = '0;
            c_rc     = '0;
            c_fl     = 1'b0;
            c_fr     = 1'b0;
            c_halt   = 1'b0;
            c_col    = '0;
            c_rows   = '0;
        end else begin
            c_left   = r_left;
            c_right  = r_right;
            c_centre = r_centre;
            c_lc     = r_lc;
            c_rc     = r_rc;
            c_fl     = r_fl;
            c_fr     = r_fr;
            c_halt   = r_halt;
            c_col    = r_col;
            c_rows   = r_rows;
        end

        pix     = i_data.pixel;
        left_s  = SW'(c_left);
        right_s = SW'(c_right);
        tol_s   = SW'(i_cfg.tolerance);
        wm1_s   = SW'(w_m1);
        col_s   = SW'(c_col);
        lb      = (left_s > tol_s) ? (left_s - tol_s) : '0;
        rsum    = right_s + tol_s;
        rb      = (rsum > wm1_s) ? wm1_s : rsum;

        lhit = pix && (c_col < c_centre) && (col_s >= lb);
        rhit = pix && (c_col > c_centre) && (col_s <= rb) && !c_fr;

        e_left   = (c_fl || lhit) ? (lhit ? c_col : c_lc) : c_left;
        e_right  = (c_fr || rhit) ? (rhit ? c_col : c_rc) : c_right;
        esum     = {1'b0, e_left} + {1'b0, e_right};
        rows_inc = c_rows + HW'(1);
        rows_s   = YW'(c_rows);
        y_full   = (rows_s < h_eff) ? (h_eff - YW'(1) - rows_s) : '0;

        n_left   = r_left;
        n_right  = r_right;
        n_centre = r_centre;
        n_lc     = r_lc;
        n_rc     = r_rc;
        n_fl     = r_fl;
        n_fr     = r_fr;
        n_halt   = r_halt;
        n_col    = r_col;
        n_rows   = r_rows;
        n_rec    = r_rec;
        n_rec.valid = 1'b0;

        if (acc) begin
            n_left   = c_left;
            n_right  = c_right;
            n_centre = c_centre;
            n_lc     = c_lc;
            n_rc     = c_rc;
            n_fl     = c_fl;
            n_fr     = c_fr;
            n_halt   = c_halt;
            n_col    = c_col;
            n_rows   = c_rows;
            if (!c_halt) begin
                if (pix && (c_col == c_centre)) begin
                    n_halt = 1'b1;
                end else if (c_col < w_m1) begin
                    if (lhit) begin
                        n_lc = c_col;
                        n_fl = 1'b1;
                    end
                    if (rhit) begin
                        n_rc = c_col;
                        n_fr = 1'b1;
                    end
                    n_col = c_col + CW'(1);
                end else begin
                    n_left      = e_left;
                    n_right     = e_right;
                    n_centre    = esum[CW:1];
                    n_rec.valid     = c_fl || lhit || c_fr || rhit;
                    n_rec.has_left  = c_fl || lhit;
                    n_rec.has_right = c_fr || rhit;
                    n_rec.left  = COORD_W'(e_left);
                    n_rec.right = COORD_W'(e_right);
                    n_rec.mid   = COORD_W'(esum[CW:1]);
                    n_rec.y     = y_full[COORD_W-1:0];
                    n_lc   = '0;
                    n_rc   = '0;
                    n_fl   = 1'b0;
                    n_fr   = 1'b0;
                    n_col  = '0;
                    n_rows = rows_inc;
                    n_halt = YW'(rows_inc) >= h_eff;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left      <= '0;
            r_right     <= RST_RIGHT;
            r_centre    <= RST_CENTRE;
            r_lc        <= '0;
            r_rc        <= '0;
            r_fl        <= 1'b0;
            r_fr        <= 1'b0;
            r_halt      <= 1'b0;
            r_col       <= '0;
            r_rows      <= '0;
            r_rec.valid <= 1'b0;
        end else begin
            r_left   <= n_left;
            r_right  <= n_right;
            r_centre <= n_centre;
            r_lc     <= n_lc;
            r_rc     <= n_rc;
            r_fl     <= n_fl;
            r_fr     <= n_fr;
            r_halt   <= n_halt;
            r_col    <= n_col;
            r_rows   <= n_rows;
            r_rec.valid <= n_rec.valid;
        end
        r_rec.has_left    <= n_rec.has_left;
        r_rec.has_right   <= n_rec.has_right;
        r_rec.left        <= n_rec.left;
        r_rec.right       <= n_rec.right;
        r_rec.mid         <= n_rec.mid;
        r_rec.y           <= n_rec.y;
    end

    `LERS_ASSERT_NEXT(a_halt_holds, i_clk, i_rst_n, r_halt && !(acc && i_data.frame_start), r_halt)
    `LERS_ASSERT_IMPL(a_rec_has_edge, i_clk, i_rst_n, r_rec.valid, r_rec.has_left || r_rec.has_right)

endmodule

[rtl/lers_queue.sv]
// Result queue: splits a finished row into result transfers and buffers them.
module lers_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  lers_pkg::t_row_rec i_rec,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output lers_pkg::t_res_out o_data
);
    import lers_pkg::*;

`include "lane_edge_row_scan_assert.svh"

    localparam int QCW = Q_AW + 2;

    t_res_out          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [QCW-1:0]    r_count, n_count;
    logic [QCW-1:0]    fill_next;
    logic [1:0]        push_n;
    logic              both, pop;
    t_res_out          items [ROW_ITEMS];

    always_comb begin
        both   = i_rec.has_left && i_rec.has_right;
        push_n = i_rec.valid ? (2'(i_rec.has_left) + 2'(i_rec.has_right) + 2'(both))
                             : 2'd0;

        items[0].kind = i_rec.has_left ? KIND_LEFT : KIND_RIGHT;
        items[0].x    = i_rec.has_left ? i_rec.left : i_rec.right;
        items[0].y    = i_rec.y;
        items[0].last = !both;
        items[1].kind = KIND_RIGHT;
        items[1].x    = i_rec.right;
        items[1].y    = i_rec.y;
        items[1].last = 1'b0;
        items[2].kind = KIND_MID;
        items[2].x    = i_rec.mid;
        items[2].y    = i_rec.y;
        items[2].last = 1'b1;
    end

    // Room for a whole row on top of what is queued and in flight.
    assign fill_next = r_count + QCW'(push_n);
    assign o_room  = fill_next <= QCW'(Q_DEPTH - ROW_ITEMS);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];
    assign pop     = o_valid && i_ready;

    always_comb begin
        n_wr    = r_wr + Q_AW'(push_n);
        n_rd    = pop ? r_rd + Q_AW'(1) : r_rd;
        n_count = r_count + QCW'(push_n) - QCW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
        for (int k = 0; k < ROW_ITEMS; k++) begin
            if (k < int'(push_n)) begin
                r_mem[r_wr + Q_AW'(k)] <= items[k];
            end
        end
    end

    `LERS_ASSERT_IMPL(a_q_no_overflow, i_clk, i_rst_n, i_rec.valid, fill_next <= QCW'(Q_DEPTH))
    `LERS_ASSERT_NEXT(a_q_stall_keeps, i_clk, i_rst_n, o_valid && !i_ready, r_count >= $past(r_count))

endmodule
